@@ rtl/mouse_look_direction_macros.svh @@
`ifndef MOUSE_LOOK_DIRECTION_MACROS_SVH
`define MOUSE_LOOK_DIRECTION_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MLD_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define MLD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mld_pkg.sv @@
package mld_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int SINE_ENTRIES = 1024;
  localparam int IDX_W        = $clog2(SINE_ENTRIES + 1);
  localparam int PHASE_W      = ANGLE_BITS - 2;
  localparam int MAG_W        = 15;
  localparam int POS_W        = 16;
  localparam int SENS_W       = 16;
  localparam int DELTA_W      = POS_W + 1;
  localparam int PROD_W       = DELTA_W + SENS_W + 1;
  localparam int FRAC_BITS    = 8;
  localparam int STEP_W       = PROD_W - FRAC_BITS - 1;
  localparam int SUM_W        = STEP_W + 1;
  localparam int DIR_W        = 16;
  localparam int PITCH_OUT_W  = 15;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(256);

  localparam longint unsigned FULL_TURN   = 64'd1 << ANGLE_BITS;
  localparam int              PITCH_MIN   = int'((FULL_TURN * 64'd1000000) / 64'd628318531);
  localparam int              PITCH_MAX   = int'(FULL_TURN / 2) - PITCH_MIN;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // taylor divisors (2n)(2n+1) as (t * m) >> s, exact for t below 2^32
  localparam int              TAYLOR_TERMS = 7;
  localparam int              TAYLOR_SHIFT [1:TAYLOR_TERMS] = '{35, 37, 38, 39, 39, 40, 40};
  localparam longint unsigned TAYLOR_RECIP [1:TAYLOR_TERMS] = '{
    ((64'd1 << 35) + 64'd5)   / 64'd6,
    ((64'd1 << 37) + 64'd19)  / 64'd20,
    ((64'd1 << 38) + 64'd41)  / 64'd42,
    ((64'd1 << 39) + 64'd71)  / 64'd72,
    ((64'd1 << 39) + 64'd109) / 64'd110,
    ((64'd1 << 40) + 64'd155) / 64'd156,
    ((64'd1 << 40) + 64'd209) / 64'd210
  };

  typedef logic [MAG_W-1:0] sine_tab_t [SINE_ENTRIES + 1];

  typedef struct packed {
    logic signed [STEP_W-1:0] dpitch;
    logic signed [STEP_W-1:0] dyaw;
  } step_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK_YAW,
    BK_LOOK_PITCH,
    BK_MUL
  } back_state_t;

  // quarter-wave sine, 32767*sin(pi/2*k/N), taylor series in q30
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    logic [95:0]     prod;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / SINE_ENTRIES;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        prod = 96'(term) * 96'(TAYLOR_RECIP[n]);
        term = 64'(prod >> TAYLOR_SHIFT[n]);
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) begin
        v = 32767;
      end
      tab[k] = v[MAG_W-1:0];
    end
    return tab;
  endfunction

endpackage

@@ rtl/mld_front.sv @@
module mld_front import mld_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] mouse_x,
  input  logic signed [POS_W-1:0] mouse_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SENS_W-1:0]       cfg_data,
  output logic                    push_valid,
  input  logic                    push_ready,
  output step_t                   push_data
);

  logic signed [POS_W-1:0]   last_x_r;
  logic signed [POS_W-1:0]   last_y_r;
  logic signed [DELTA_W-1:0] dx_r;
  logic signed [DELTA_W-1:0] dy_r;
  logic                      s1_valid_r;
  logic [SENS_W-1:0]         sens_r;
  logic                      accept;

  // delta times sensitivity, 8 fraction bits dropped toward zero
  function automatic logic signed [STEP_W-1:0] scale(logic signed [DELTA_W-1:0] d,
                                                     logic [SENS_W-1:0] s);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] sh;
    p   = PROD_W'(d) * PROD_W'($signed({1'b0, s}));
    adj = p + $signed({{(PROD_W - FRAC_BITS){1'b0}}, {FRAC_BITS{p[PROD_W-1]}}});
    sh  = adj >>> FRAC_BITS;
    return sh[STEP_W-1:0];
  endfunction

  assign cfg_ready      = 1'b1;
  assign push_valid     = s1_valid_r;
  assign in_ready       = !s1_valid_r || push_ready;
  assign accept         = in_valid && in_ready;
  assign push_data.dyaw   = scale(dx_r, sens_r);
  assign push_data.dpitch = scale(dy_r, sens_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      sens_r     <= SENS_RESET;
    end else begin
      if (cfg_valid) begin
        sens_r <= cfg_data;
      end
      if (accept) begin
        last_x_r   <= mouse_x;
        last_y_r   <= mouse_y;
        s1_valid_r <= 1'b1;
      end else if (push_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r <= DELTA_W'(mouse_x) - DELTA_W'(last_x_r);
      dy_r <= DELTA_W'(mouse_y) - DELTA_W'(last_y_r);
    end
  end

endmodule

@@ rtl/mld_queue.sv @@
module mld_queue import mld_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  step_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output step_t pop_data
);

  step_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count_r != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/mld_back.sv @@
module mld_back import mld_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  step_t                       pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DIR_W-1:0]     dir_x,
  output logic signed [DIR_W-1:0]     dir_y,
  output logic signed [DIR_W-1:0]     dir_z,
  output logic [ANGLE_BITS-1:0]       yaw_angle,
  output logic [PITCH_OUT_W-1:0]      pitch_angle
);

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam logic signed [SUM_W-1:0] PMIN_S = SUM_W'(PITCH_MIN);
  localparam logic signed [SUM_W-1:0] PMAX_S = SUM_W'(PITCH_MAX);
  localparam logic [ANGLE_BITS-1:0]   QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  back_state_t               state_r;
  back_state_t               state_nxt;
  logic [ANGLE_BITS-1:0]     yaw_r;
  logic [ANGLE_BITS-1:0]     yaw_nxt;
  logic [ANGLE_BITS-1:0]     pitch_r;
  logic [ANGLE_BITS-1:0]     pitch_nxt;
  logic signed [SUM_W-1:0]   pitch_sum;
  logic [ANGLE_BITS-1:0]     ang_a;
  logic [ANGLE_BITS-1:0]     ang_b;
  logic [IDX_W:0]            ref_a;
  logic [IDX_W:0]            ref_b;
  logic [MAG_W-1:0]          rd_a_r;
  logic [MAG_W-1:0]          rd_b_r;
  logic [MAG_W-1:0]          sy_mag_r;
  logic [MAG_W-1:0]          cy_mag_r;
  logic                      sy_neg_r;
  logic                      cy_neg_r;
  logic                      load_out;
  logic [2*MAG_W-1:0]        prod_z;
  logic [2*MAG_W-1:0]        prod_x;
  logic [2*MAG_W-1:0]        rnd_z;
  logic [2*MAG_W-1:0]        rnd_x;
  logic [MAG_W-1:0]          mag_z;
  logic [MAG_W-1:0]          mag_x;
  logic signed [DIR_W-1:0]   dz_nxt;
  logic signed [DIR_W-1:0]   dx_nxt;
  logic signed [DIR_W-1:0]   dy_nxt;
  logic                      out_valid_r;
  logic signed [DIR_W-1:0]   dir_x_r;
  logic signed [DIR_W-1:0]   dir_y_r;
  logic signed [DIR_W-1:0]   dir_z_r;
  logic [ANGLE_BITS-1:0]     yaw_out_r;
  logic [PITCH_OUT_W-1:0]    pitch_out_r;

  // {negate, table address} for one angle
  function automatic logic [IDX_W:0] sine_ref(logic [ANGLE_BITS-1:0] a);
    logic [1:0]               quad;
    logic [PHASE_W+IDX_W-1:0] scaled;
    logic [PHASE_W+IDX_W-1:0] idx_full;
    logic [IDX_W-1:0]         idx;
    quad     = a[ANGLE_BITS-1 -: 2];
    scaled   = (PHASE_W + IDX_W)'(a[PHASE_W-1:0]) * (PHASE_W + IDX_W)'(SINE_ENTRIES);
    idx_full = scaled >> PHASE_W;
    if (idx_full > (PHASE_W + IDX_W)'(SINE_ENTRIES)) begin
      idx = IDX_W'(SINE_ENTRIES);
    end else begin
      idx = idx_full[IDX_W-1:0];
    end
    if (quad[0]) begin
      idx = IDX_W'(SINE_ENTRIES) - idx;
    end
    return {quad[1], idx};
  endfunction

  function automatic logic signed [DIR_W-1:0] apply_sign(logic neg, logic [MAG_W-1:0] m);
    logic signed [DIR_W-1:0] v;
    v = $signed(DIR_W'(m));
    return neg ? -v : v;
  endfunction

  assign pitch_sum = SUM_W'($signed({1'b0, pitch_r})) + SUM_W'(pop_data.dpitch);
  assign ang_a     = (state_r == BK_LOOK_YAW) ? yaw_r : pitch_r;
  assign ang_b     = ang_a + QUARTER;
  assign ref_a     = sine_ref(ang_a);
  assign ref_b     = sine_ref(ang_b);

  // in multiply state the rom ports hold sin and cos of pitch
  assign prod_z = (2*MAG_W)'(sy_mag_r) * (2*MAG_W)'(rd_a_r);
  assign prod_x = (2*MAG_W)'(cy_mag_r) * (2*MAG_W)'(rd_a_r);
  assign rnd_z  = prod_z + (2*MAG_W)'(16384);
  assign rnd_x  = prod_x + (2*MAG_W)'(16384);
  assign mag_z  = rnd_z[2*MAG_W-1:MAG_W];
  assign mag_x  = rnd_x[2*MAG_W-1:MAG_W];
  assign dz_nxt = apply_sign(sy_neg_r ^ ref_a[IDX_W], mag_z);
  assign dx_nxt = apply_sign(!(cy_neg_r ^ ref_a[IDX_W]), mag_x);
  assign dy_nxt = apply_sign(ref_b[IDX_W], rd_b_r);

  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    load_out  = 1'b0;
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;
    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          yaw_nxt = yaw_r + pop_data.dyaw[ANGLE_BITS-1:0];
          if (pitch_sum < PMIN_S) begin
            pitch_nxt = ANGLE_BITS'(PITCH_MIN);
          end else if (pitch_sum > PMAX_S) begin
            pitch_nxt = ANGLE_BITS'(PITCH_MAX);
          end else begin
            pitch_nxt = pitch_sum[ANGLE_BITS-1:0];
          end
          state_nxt = BK_LOOK_YAW;
        end
      end
      BK_LOOK_YAW: begin
        state_nxt = BK_LOOK_PITCH;
      end
      BK_LOOK_PITCH: begin
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      yaw_r       <= '0;
      pitch_r     <= QUARTER;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sine rom, two registered read ports
  always_ff @(posedge clk) begin
    rd_a_r <= SINE_TAB[ref_a[IDX_W-1:0]];
    rd_b_r <= SINE_TAB[ref_b[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_LOOK_YAW) begin
      sy_neg_r <= ref_a[IDX_W];
      cy_neg_r <= ref_b[IDX_W];
    end
    if (state_r == BK_LOOK_PITCH) begin
      sy_mag_r <= rd_a_r;
      cy_mag_r <= rd_b_r;
    end
    if (load_out) begin
      dir_x_r     <= dx_nxt;
      dir_y_r     <= dy_nxt;
      dir_z_r     <= dz_nxt;
      yaw_out_r   <= yaw_r;
      pitch_out_r <= pitch_r[PITCH_OUT_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign dir_x       = dir_x_r;
  assign dir_y       = dir_y_r;
  assign dir_z       = dir_z_r;
  assign yaw_angle   = yaw_out_r;
  assign pitch_angle = pitch_out_r;

endmodule

@@ rtl/mouse_look_direction.sv @@
// channel   dir  handshake                   payload
// in_       in   in_tvalid / in_tready       in_tdata: mouse_x, mouse_y
// out_      out  out_tvalid / out_tready     out_tdata: dir_x, dir_y, dir_z, yaw, pitch
// cfg_      in   cfg_valid / cfg_ready       cfg_data: sensitivity
//
// the back end sets the pace: it pops the queue and updates the angles, then reads
// the sine rom for yaw and then for pitch on its two ports, then multiplies into
// the output register, and pops no new item until it is through with the last;
// the front end registers each delta and a two-entry queue absorbs stalls.
// rst_n is synchronous, active low; cfg_ready is always high.
`include "mouse_look_direction_macros.svh"

module mouse_look_direction import mld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // mouse_x[15:0], mouse_y[31:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [79:0]       out_tdata,  // dir_x[15:0], dir_y[31:16], dir_z[47:32],
                                        // yaw_angle[63:48], pitch_angle[78:64], zero[79]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SENS_W-1:0] cfg_data
);

  logic                       push_valid;
  logic                       push_ready;
  step_t                      push_data;
  logic                       pop_valid;
  logic                       pop_ready;
  step_t                      pop_data;
  logic signed [DIR_W-1:0]    dir_x;
  logic signed [DIR_W-1:0]    dir_y;
  logic signed [DIR_W-1:0]    dir_z;
  logic [ANGLE_BITS-1:0]      yaw_angle;
  logic [PITCH_OUT_W-1:0]     pitch_angle;

  mld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .mouse_x    ($signed(in_tdata[15:0])),
    .mouse_y    ($signed(in_tdata[31:16])),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mld_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .yaw_angle   (yaw_angle),
    .pitch_angle (pitch_angle)
  );

  assign out_tdata = {1'b0, pitch_angle, yaw_angle, dir_z, dir_y, dir_x};

  `MLD_CHECK(a_pitch_range, out_tvalid, (int'(out_tdata[78:64]) >= PITCH_MIN) && (int'(out_tdata[78:64]) <= PITCH_MAX), "pitch outside clamp range")
  `MLD_CHECK(a_dir_no_min, out_tvalid, (out_tdata[15:0] != 16'h8000) && (out_tdata[31:16] != 16'h8000) && (out_tdata[47:32] != 16'h8000), "direction component at -1.0")
  `MLD_CHECK(a_level_y_zero, out_tvalid && (out_tdata[78:64] == 15'd16384), out_tdata[31:16] == 16'h0000, "level pitch gives nonzero y")

endmodule
